// File: src/pps_pkg.sv
package pps_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_TIME_BITS = 16;

  localparam int ARRIVAL_W  = 16;
  localparam int BURST_W    = 8;
  localparam int PRIO_W     = 8;
  localparam int ID_W       = 7;
  localparam int OUT_TIME_W = 16;
  localparam int IO_DELAY_W = 8;

  localparam logic [IO_DELAY_W-1:0] IO_DELAY_RESET = 8'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DEC,
    S_STEP,
    S_COMP,
    S_TURN,
    S_WAIT,
    S_EMIT,
    S_PRE,
    S_MAIN
  } state_t;

  typedef enum logic {
    ALU_SATADD,
    ALU_CSUB
  } alu_op_t;

  typedef struct packed {
    logic [ID_W-1:0]       running_id;
    logic                  seg_valid;
    logic [ID_W-1:0]       seg_id;
    logic [OUT_TIME_W-1:0] seg_start;
    logic [OUT_TIME_W-1:0] seg_end;
    logic                  done_valid;
    logic [OUT_TIME_W-1:0] done_completion;
    logic [OUT_TIME_W-1:0] done_turnaround;
    logic [OUT_TIME_W-1:0] done_waiting;
    logic                  all_done;
    logic                  last;
  } result_t;

  // entry index width, at least one bit
  function automatic int idx_width(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // width of a count that can hold n itself
  function automatic int cnt_width(int n);
    return $clog2(n + 1);
  endfunction

  // time arithmetic is wide enough for both the clock and an arrival
  function automatic int calc_width(int tb);
    return (tb > ARRIVAL_W) ? tb : ARRIVAL_W;
  endfunction

endpackage

// File: src/preemptive_priority_scheduler_top.sv
// preemptive priority scheduler. a load beat (mode 0) appends a task entry
// (arrival, burst, prio) and returns nothing; loads beyond MAX_TASKS entries
// are dropped. a tick beat (mode 1) advances time by one unit: the entries
// are scanned for the arrived task with remaining burst and the lowest prio
// number (ties to earlier arrival, then lower entry), the displaced task's
// gantt segment is closed if it is nonempty, and the chosen task runs one
// unit. a tick returns one result beat, or two when a preemption segment is
// closed; last marks the final beat. time and completion saturate at
// 2^TIME_BITS-1, turnaround and waiting clamp at zero. a tick holds
// in_stall while the entries go past the shared compare unit one per cycle
// through the single read port of the task memory and, when the task
// finishes, while the completion math runs three steps on one saturating
// add / clamped subtract unit. the block takes no new beat until all
// result beats of a tick are accepted. io_delay (reset 2) is written with
// cfg_wr_en; the user must write it only while the block is idle, which
// the block itself does not enforce.
module preemptive_priority_scheduler_top #(
  parameter int MAX_TASKS = pps_pkg::DEF_MAX_TASKS,
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [pps_pkg::ARRIVAL_W-1:0]    arrival,
  input  logic [pps_pkg::BURST_W-1:0]      burst,
  input  logic [pps_pkg::PRIO_W-1:0]       prio,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pps_pkg::ID_W-1:0]         running_id,
  output logic                             seg_valid,
  output logic [pps_pkg::ID_W-1:0]         seg_id,
  output logic [pps_pkg::OUT_TIME_W-1:0]   seg_start,
  output logic [pps_pkg::OUT_TIME_W-1:0]   seg_end,
  output logic                             done_valid,
  output logic [pps_pkg::OUT_TIME_W-1:0]   done_completion,
  output logic [pps_pkg::OUT_TIME_W-1:0]   done_turnaround,
  output logic [pps_pkg::OUT_TIME_W-1:0]   done_waiting,
  output logic                             all_done,
  output logic                             last,
  // io_delay register
  input  logic                             cfg_wr_en,
  input  logic [pps_pkg::IO_DELAY_W-1:0]   cfg_wr_data
);
  import pps_pkg::*;

  localparam int IW = idx_width(MAX_TASKS);
  localparam int CW = cnt_width(MAX_TASKS);
  localparam int AW = calc_width(TIME_BITS);

  state_t state, state_next;

  logic [IO_DELAY_W-1:0] io_delay;

  // scheduler state
  logic [CW-1:0]        task_count;
  logic [CW-1:0]        finished_count;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] switch_time;
  logic                 cur_valid;
  logic [IW-1:0]        cur_task;

  // scan
  logic [CW-1:0] scan_idx;
  logic          scan_issue;
  logic          cand_valid;
  logic [IW-1:0] cand_idx;

  // per tick working registers
  logic                 pre_valid;
  logic [IW-1:0]        pre_id;
  logic [TIME_BITS-1:0] pre_start;
  logic [TIME_BITS-1:0] pre_end;
  logic                 fin;
  logic [ARRIVAL_W-1:0] step_arrival;
  logic [BURST_W-1:0]   step_burst;
  logic [AW-1:0]        comp;
  logic [AW-1:0]        turn;
  logic [AW-1:0]        wait_time;

  // handshakes
  logic in_fire;
  logic out_fire;
  logic load_we;
  logic tick_start;

  // memory ports
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [ARRIVAL_W-1:0] rd_arrival;
  logic [BURST_W-1:0]   rd_burst;
  logic [PRIO_W-1:0]    rd_prio;
  logic [BURST_W-1:0]   rd_rem;
  logic                 rem_wr_en;
  logic [IW-1:0]        rem_wr_addr;
  logic [BURST_W-1:0]   rem_wr_data;
  logic                 step_we;

  // pick unit
  logic          found;
  logic [IW-1:0] best_idx;
  logic          change;

  // shared arithmetic unit
  alu_op_t       alu_op;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_cin;
  logic [AW-1:0] alu_res;

  // result beats
  result_t pre_res;
  result_t main_res;
  result_t out_q;
  logic [ID_W-1:0] run_id;
  logic            all_now;

  assign in_fire    = in_valid && !in_stall;
  assign out_fire   = out_valid && !out_stall;
  assign load_we    = in_fire && (mode == MODE_LOAD) && (task_count != CW'(MAX_TASKS));
  assign tick_start = in_fire && (mode == MODE_TICK);
  assign scan_issue = (state == S_SCAN) && (scan_idx != task_count);
  assign step_we    = (state == S_STEP) && cur_valid;

  // the pick differs from what ran last
  assign change = (found != cur_valid) || (found && (best_idx != cur_task));

  // one read port: scan entries in order, then the chosen task once
  assign rd_en   = scan_issue || (state == S_DEC);
  assign rd_addr = (state == S_DEC) ? best_idx : scan_idx[IW-1:0];

  // load seeds remaining with the burst, a run step counts it down
  assign rem_wr_en   = load_we || step_we;
  assign rem_wr_addr = load_we ? task_count[IW-1:0] : cur_task;
  assign rem_wr_data = load_we ? burst : (rd_rem - BURST_W'(1));

  pps_store #(
    .MAX_TASKS (MAX_TASKS)
  ) u_store (
    .clk         (clk),
    .wr_en       (load_we),
    .wr_addr     (task_count[IW-1:0]),
    .wr_arrival  (arrival),
    .wr_burst    (burst),
    .wr_prio     (prio),
    .rem_wr_en   (rem_wr_en),
    .rem_wr_addr (rem_wr_addr),
    .rem_wr_data (rem_wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_arrival  (rd_arrival),
    .rd_burst    (rd_burst),
    .rd_prio     (rd_prio),
    .rd_rem      (rd_rem)
  );

  pps_pick #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk          (clk),
    .rst          (rst),
    .clear        (tick_start),
    .cand_valid   (cand_valid),
    .cand_idx     (cand_idx),
    .cand_arrival (rd_arrival),
    .cand_prio    (rd_prio),
    .cand_rem     (rd_rem),
    .now          (now),
    .found        (found),
    .best_idx     (best_idx)
  );

  // operand select for the shared unit
  always_comb begin
    case (state)
      S_STEP: begin
        alu_op  = ALU_SATADD;
        alu_a   = AW'(now);
        alu_b   = '0;
        alu_cin = 1'b1;
      end
      S_COMP: begin
        alu_op  = ALU_SATADD;
        alu_a   = AW'(now);
        alu_b   = AW'(io_delay);
        alu_cin = 1'b0;
      end
      S_TURN: begin
        alu_op  = ALU_CSUB;
        alu_a   = comp;
        alu_b   = AW'(step_arrival);
        alu_cin = 1'b0;
      end
      S_WAIT: begin
        alu_op  = ALU_CSUB;
        alu_a   = turn;
        alu_b   = AW'(step_burst);
        alu_cin = 1'b0;
      end
      default: begin
        alu_op  = ALU_SATADD;
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
      end
    endcase
  end

  pps_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .cin (alu_cin),
    .res (alu_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (tick_start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // the last candidate is judged on the cycle no read goes out
        if (!scan_issue) begin
          state_next = S_DEC;
        end
      end
      S_DEC:  state_next = S_STEP;
      S_STEP: state_next = (cur_valid && (rd_rem == BURST_W'(1))) ? S_COMP : S_EMIT;
      S_COMP: state_next = S_TURN;
      S_TURN: state_next = S_WAIT;
      S_WAIT: state_next = S_EMIT;
      S_EMIT: state_next = pre_valid ? S_PRE : S_MAIN;
      S_PRE: begin
        if (out_fire) begin
          state_next = S_MAIN;
        end
      end
      S_MAIN: begin
        if (out_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      io_delay <= IO_DELAY_RESET;
    end else if (cfg_wr_en) begin
      io_delay <= cfg_wr_data;
    end
  end

  // scheduler control state
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count     <= '0;
      finished_count <= '0;
      now            <= '0;
      switch_time    <= '0;
      cur_valid      <= 1'b0;
      cur_task       <= '0;
      scan_idx       <= '0;
      cand_valid     <= 1'b0;
      pre_valid      <= 1'b0;
      fin            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      cand_valid <= scan_issue;
      if (load_we) begin
        task_count <= task_count + CW'(1);
      end
      if (tick_start) begin
        scan_idx <= '0;
      end else if (scan_issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      case (state)
        S_DEC: begin
          // close the displaced task's segment unless it is empty
          pre_valid <= change && cur_valid && (now > switch_time);
          if (change) begin
            cur_valid   <= found;
            cur_task    <= best_idx;
            switch_time <= now;
          end
        end
        S_STEP: begin
          now <= alu_res[TIME_BITS-1:0];
          fin <= cur_valid && (rd_rem == BURST_W'(1));
          if (cur_valid && (rd_rem == BURST_W'(1))) begin
            cur_valid      <= 1'b0;
            finished_count <= finished_count + CW'(1);
          end
        end
        S_EMIT: out_valid <= 1'b1;
        S_MAIN: begin
          if (out_fire) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // per tick payload
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      cand_idx <= scan_idx[IW-1:0];
    end
    if (state == S_DEC) begin
      pre_id    <= cur_task;
      pre_start <= switch_time;
      pre_end   <= now;
    end
    if (state == S_STEP) begin
      step_arrival <= rd_arrival;
      step_burst   <= rd_burst;
    end
    if (state == S_COMP) begin
      comp <= alu_res;
    end
    if (state == S_TURN) begin
      turn <= alu_res;
    end
    if (state == S_WAIT) begin
      wait_time <= alu_res;
    end
  end

  assign run_id  = found ? (ID_W'(best_idx) + ID_W'(1)) : '0;
  assign all_now = (finished_count == task_count);

  // preemption beat: closed segment only
  always_comb begin
    pre_res            = '0;
    pre_res.running_id = run_id;
    pre_res.seg_valid  = 1'b1;
    pre_res.seg_id     = ID_W'(pre_id) + ID_W'(1);
    pre_res.seg_start  = OUT_TIME_W'(pre_start);
    pre_res.seg_end    = OUT_TIME_W'(pre_end);
    pre_res.all_done   = all_now;
    pre_res.last       = 1'b0;
  end

  // final beat of the tick, with the finishing segment and report if any
  always_comb begin
    main_res            = '0;
    main_res.running_id = run_id;
    main_res.all_done   = all_now;
    main_res.last       = 1'b1;
    if (fin) begin
      main_res.seg_valid       = 1'b1;
      main_res.seg_id          = ID_W'(cur_task) + ID_W'(1);
      main_res.seg_start       = OUT_TIME_W'(switch_time);
      main_res.seg_end         = OUT_TIME_W'(now);
      main_res.done_valid      = 1'b1;
      main_res.done_completion = OUT_TIME_W'(comp);
      main_res.done_turnaround = OUT_TIME_W'(turn);
      main_res.done_waiting    = OUT_TIME_W'(wait_time);
    end
  end

  // output register holds each beat until taken
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      out_q <= pre_valid ? pre_res : main_res;
    end else if ((state == S_PRE) && out_fire) begin
      out_q <= main_res;
    end
  end

  assign running_id      = out_q.running_id;
  assign seg_valid       = out_q.seg_valid;
  assign seg_id          = out_q.seg_id;
  assign seg_start       = out_q.seg_start;
  assign seg_end         = out_q.seg_end;
  assign done_valid      = out_q.done_valid;
  assign done_completion = out_q.done_completion;
  assign done_turnaround = out_q.done_turnaround;
  assign done_waiting    = out_q.done_waiting;
  assign all_done        = out_q.all_done;
  assign last            = out_q.last;

endmodule

// File: src/pps_store.sv
module pps_store #(
  parameter int MAX_TASKS = pps_pkg::DEF_MAX_TASKS
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [pps_pkg::idx_width(MAX_TASKS)-1:0] wr_addr,
  input  logic [pps_pkg::ARRIVAL_W-1:0]          wr_arrival,
  input  logic [pps_pkg::BURST_W-1:0]            wr_burst,
  input  logic [pps_pkg::PRIO_W-1:0]             wr_prio,
  input  logic                                   rem_wr_en,
  input  logic [pps_pkg::idx_width(MAX_TASKS)-1:0] rem_wr_addr,
  input  logic [pps_pkg::BURST_W-1:0]            rem_wr_data,
  input  logic                                   rd_en,
  input  logic [pps_pkg::idx_width(MAX_TASKS)-1:0] rd_addr,
  output logic [pps_pkg::ARRIVAL_W-1:0]          rd_arrival,
  output logic [pps_pkg::BURST_W-1:0]            rd_burst,
  output logic [pps_pkg::PRIO_W-1:0]             rd_prio,
  output logic [pps_pkg::BURST_W-1:0]            rd_rem
);
  import pps_pkg::*;

  localparam int WORD_W = ARRIVAL_W + BURST_W + PRIO_W;

  // static task fields, written on load only
  logic [WORD_W-1:0]  task_mem [MAX_TASKS];
  // remaining burst, written on load and on every run step
  logic [BURST_W-1:0] rem_mem  [MAX_TASKS];
  logic [WORD_W-1:0]  task_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      task_mem[wr_addr] <= {wr_arrival, wr_burst, wr_prio};
    end
    if (rd_en) begin
      task_word <= task_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rem_wr_en) begin
      rem_mem[rem_wr_addr] <= rem_wr_data;
    end
    if (rd_en) begin
      rd_rem <= rem_mem[rd_addr];
    end
  end

  assign rd_arrival = task_word[WORD_W-1 -: ARRIVAL_W];
  assign rd_burst   = task_word[PRIO_W +: BURST_W];
  assign rd_prio    = task_word[PRIO_W-1:0];

endmodule

// File: src/pps_pick.sv
module pps_pick #(
  parameter int MAX_TASKS = pps_pkg::DEF_MAX_TASKS,
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  logic                                   cand_valid,
  input  logic [pps_pkg::idx_width(MAX_TASKS)-1:0] cand_idx,
  input  logic [pps_pkg::ARRIVAL_W-1:0]          cand_arrival,
  input  logic [pps_pkg::PRIO_W-1:0]             cand_prio,
  input  logic [pps_pkg::BURST_W-1:0]            cand_rem,
  input  logic [TIME_BITS-1:0]                   now,
  output logic                                   found,
  output logic [pps_pkg::idx_width(MAX_TASKS)-1:0] best_idx
);
  import pps_pkg::*;

  localparam int AW = calc_width(TIME_BITS);

  logic [PRIO_W-1:0]    best_prio;
  logic [ARRIVAL_W-1:0] best_arrival;
  logic                 ready;
  logic                 better;

  // arrived and still has burst left
  assign ready  = (cand_rem != '0) && (AW'(cand_arrival) <= AW'(now));
  // strict compares keep the lower index on a full tie
  assign better = ready && (!found || (cand_prio < best_prio) ||
                  ((cand_prio == best_prio) && (cand_arrival < best_arrival)));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (cand_valid && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_valid && better) begin
      best_idx     <= cand_idx;
      best_prio    <= cand_prio;
      best_arrival <= cand_arrival;
    end
  end

endmodule

// File: src/pps_alu.sv
module pps_alu #(
  parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS
) (
  input  pps_pkg::alu_op_t                        op,
  input  logic [pps_pkg::calc_width(TIME_BITS)-1:0] a,
  input  logic [pps_pkg::calc_width(TIME_BITS)-1:0] b,
  input  logic                                    cin,
  output logic [pps_pkg::calc_width(TIME_BITS)-1:0] res
);
  import pps_pkg::*;

  localparam int AW = calc_width(TIME_BITS);
  localparam logic [AW:0] TIME_MAX = (AW+1)'((64'd1 << TIME_BITS) - 64'd1);

  logic [AW:0] sum;

  assign sum = {1'b0, a} + {1'b0, b} + (AW+1)'(cin);

  always_comb begin
    case (op)
      ALU_SATADD: res = (sum > TIME_MAX) ? TIME_MAX[AW-1:0] : sum[AW-1:0];
      ALU_CSUB:   res = (a >= b) ? (a - b) : '0;
      default:    res = '0;
    endcase
  end

endmodule
